// ----- src/akf_pkg.sv -----
//------------------------------------------------------------------------------
// akf_pkg: shared types and constants of the angle fusion filter
// Payload structs, register indexes and signed 32-bit limits.
//------------------------------------------------------------------------------
`default_nettype none
package akf_pkg;
   typedef struct packed {
      logic signed [31:0] angle_meas;
      logic signed [31:0] gyro_meas;
   } req_type;

   typedef struct packed {
      logic signed [31:0] angle_est;
      logic signed [31:0] rate_est;
   } rsp_type;

   localparam logic [2:0] REG_ANGLE_NOISE = 3'd0;
   localparam logic [2:0] REG_RATE_NOISE  = 3'd1;
   localparam logic [2:0] REG_MEAS_NOISE  = 3'd2;
   localparam logic [2:0] REG_TIME_STEP   = 3'd3;
   localparam logic [2:0] REG_OBS_GAIN    = 3'd4;
   localparam logic [2:0] REG_POST_BLEND  = 3'd5;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sd1;
endpackage
`default_nettype wire

// ----- src/angle_kalman_fusion.sv -----
//------------------------------------------------------------------------------
// angle_kalman_fusion: two-state Kalman filter for angle and gyro bias
// One shared multiplier and one restoring divider under a step sequencer.
//------------------------------------------------------------------------------
// Usage:
//   req_ carries one sample (accelerometer angle, gyro rate); it is taken
//   when req_valid is high and req_stall low. req_stall is high in reset,
//   while a sample is being processed and while its result still waits.
//   rsp_ gives one item per sample (filtered angle, bias-corrected rate),
//   held in an output register until rsp_stall is low.
//   csr_ writes the filter registers; write only while the block is idle.
// Steps: from acceptance to rsp_valid the sequencer runs the multiply
//   steps (sixteen with post_blend set), a few add steps and two
//   serial divisions. A variance that is not positive skips both
//   divisions.
// Throughput: one item at a time; no new sample is taken while one is
//   being processed.
// Reset: the registers take their documented values, angle and bias clear,
//   covariance becomes the identity and the output register empties.
// A stalled result holds the block: no new sample is taken until it leaves.
//------------------------------------------------------------------------------
`default_nettype none
module angle_kalman_fusion #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire akf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output akf_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data
);
   import akf_pkg::*;

   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
   localparam int DW = 34 + FRAC_BITS;   // dividend magnitude width
   localparam int CW = $clog2(DW + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RATE, S_ANG, S_D0, S_P00, S_P01, S_P11, S_ERR,
      S_PC0, S_PC1, S_T1, S_E, S_K0, S_DIV0, S_K1, S_DIV1,
      S_U00, S_U01, S_U10, S_U11, S_UA, S_UB, S_DEV, S_X, S_BL, S_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] an_ff, rn_ff, mn_ff;
   logic [15:0] dt_ff;
   logic signed [31:0] c_ff;
   logic pb_ff;
   logic signed [31:0] ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] zm_ff, gm_ff, rate_ff, d_ff, err_ff;
   logic signed [31:0] pc0_ff, pc1_ff, t1_ff, k0_ff, k1_ff;
   logic signed [34:0] e_ff;
   logic [DW-1:0] quo_ff;
   logic [DW:0]   rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          neg_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   // shared multiplier operands
   logic signed [31:0] ma;
   logic signed [32:0] mb;
   logic signed [64:0] prod;
   logic signed [65:0] prnd;
   logic signed [65:0] qsh;
   logic signed [31:0] qm;

   function automatic logic signed [31:0] sat(input logic signed [35:0] v);
      if (v > 36'(S32_MAX)) return S32_MAX;
      if (v < 36'(S32_MIN)) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] add2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return sat(36'(a) + 36'(b));
   endfunction

   function automatic logic signed [31:0] sub2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return sat(36'(a) - 36'(b));
   endfunction

   always_comb begin
      ma = 32'sd0;
      mb = 33'sd0;
      case (state_ff)
         S_ANG:  begin ma = rate_ff; mb = $signed({17'd0, dt_ff}); end
         S_P00, S_P01, S_P11, S_BL: begin
            ma = d_ff; mb = $signed({17'd0, dt_ff});
         end
         S_PC0:  begin ma = c_ff; mb = 33'(p00_ff); end
         S_PC1:  begin ma = c_ff; mb = 33'(p10_ff); end
         S_T1:   begin ma = c_ff; mb = 33'(p01_ff); end
         S_E:    begin ma = c_ff; mb = 33'(pc0_ff); end
         S_U00:  begin ma = k0_ff; mb = 33'(pc0_ff); end
         S_U01:  begin ma = k0_ff; mb = 33'(t1_ff); end
         S_U10:  begin ma = k1_ff; mb = 33'(pc0_ff); end
         S_U11:  begin ma = k1_ff; mb = 33'(t1_ff); end
         S_UA:   begin ma = k0_ff; mb = 33'(err_ff); end
         S_UB:   begin ma = k1_ff; mb = 33'(err_ff); end
         // meas_noise enters as unsigned
         S_X:    begin ma = d_ff; mb = $signed({1'b0, mn_ff}); end
         default: begin ma = 32'sd0; mb = 33'sd0; end
      endcase
      prod = 65'(ma) * 65'(mb);
      prnd = 66'(prod) + (66'sd1 <<< (FRAC_BITS - 1));
      qsh  = prnd >>> FRAC_BITS;
      if (qsh > 66'(S32_MAX))      qm = S32_MAX;
      else if (qsh < 66'(S32_MIN)) qm = S32_MIN;
      else                         qm = qsh[31:0];
   end

   // restoring divider step
   logic [DW:0] rem_sh, rem_sub;
   logic [33:0] e_mag;
   logic signed [DW:0] q_signed;
   logic signed [31:0] q_sat;
   always_comb begin
      e_mag   = e_ff[33:0];
      rem_sh  = {rem_ff[DW-1:0], quo_ff[DW-1]};
      rem_sub = rem_sh - (DW+1)'(e_mag);
      q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (q_signed > (DW+1)'(S32_MAX))      q_sat = S32_MAX;
      else if (q_signed < (DW+1)'(S32_MIN)) q_sat = S32_MIN;
      else                                  q_sat = q_signed[31:0];
   end

   function automatic logic [DW-1:0] dividend(input logic signed [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? 32'(-33'(v)) : v;
      return DW'(mag) << FRAC_BITS;
   endfunction

   assign req_stall = reset || (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         an_ff <= 32'd66; rn_ff <= 32'd197; mn_ff <= 32'd32768;
         dt_ff <= 16'd655; c_ff <= ONE_Q; pb_ff <= 1'b1;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= ONE_Q; p01_ff <= '0; p10_ff <= '0; p11_ff <= ONE_Q;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               REG_ANGLE_NOISE: an_ff <= csr_data;
               REG_RATE_NOISE:  rn_ff <= csr_data;
               REG_MEAS_NOISE:  mn_ff <= csr_data;
               REG_TIME_STEP:   dt_ff <= csr_data[15:0];
               REG_OBS_GAIN:    c_ff  <= $signed(csr_data);
               REG_POST_BLEND:  pb_ff <= csr_data[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  zm_ff <= req_data.angle_meas;
                  gm_ff <= req_data.gyro_meas;
                  state_ff <= S_RATE;
               end
            end
            S_RATE: begin rate_ff <= sub2(gm_ff, bias_ff); state_ff <= S_ANG; end
            S_ANG:  begin ang_ff <= add2(ang_ff, qm); state_ff <= S_D0; end
            S_D0: begin
               d_ff <= sat(36'($signed({1'b0, an_ff})) - 36'(p01_ff) - 36'(p10_ff));
               state_ff <= S_P00;
            end
            S_P00: begin
               p00_ff <= add2(p00_ff, qm);
               d_ff <= sub2(32'sd0, p11_ff);
               state_ff <= S_P01;
            end
            S_P01: begin
               // both off-diagonal terms take the same increment
               p01_ff <= add2(p01_ff, qm);
               p10_ff <= add2(p10_ff, qm);
               d_ff <= rn_ff[31] ? S32_MAX : $signed(rn_ff);
               state_ff <= S_P11;
            end
            S_P11: begin p11_ff <= add2(p11_ff, qm); state_ff <= S_ERR; end
            S_ERR: begin err_ff <= sub2(zm_ff, ang_ff); state_ff <= S_PC0; end
            S_PC0: begin pc0_ff <= qm; state_ff <= S_PC1; end
            S_PC1: begin pc1_ff <= qm; state_ff <= S_T1; end
            S_T1:  begin t1_ff <= qm; state_ff <= S_E; end
            S_E: begin
               e_ff <= $signed({3'b000, mn_ff}) + 35'(qm);
               state_ff <= S_K0;
            end
            S_K0: begin
               quo_ff <= dividend(pc0_ff); rem_ff <= '0;
               neg_ff <= pc0_ff[31]; cnt_ff <= CW'(DW);
               if (e_ff <= 35'sd0) begin
                  k0_ff <= '0; k1_ff <= '0; state_ff <= S_U00;
               end else begin
                  state_ff <= S_DIV0;
               end
            end
            S_DIV0, S_DIV1: begin
               if (cnt_ff == '0) begin
                  if (state_ff == S_DIV0) begin
                     k0_ff <= q_sat; state_ff <= S_K1;
                  end else begin
                     k1_ff <= q_sat; state_ff <= S_U00;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
                  if (!rem_sub[DW]) begin
                     rem_ff <= rem_sub; quo_ff <= {quo_ff[DW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;  quo_ff <= {quo_ff[DW-2:0], 1'b0};
                  end
               end
            end
            S_K1: begin
               quo_ff <= dividend(pc1_ff); rem_ff <= '0;
               neg_ff <= pc1_ff[31]; cnt_ff <= CW'(DW);
               state_ff <= S_DIV1;
            end
            S_U00: begin p00_ff <= sub2(p00_ff, qm); state_ff <= S_U01; end
            S_U01: begin p01_ff <= sub2(p01_ff, qm); state_ff <= S_U10; end
            S_U10: begin p10_ff <= sub2(p10_ff, qm); state_ff <= S_U11; end
            S_U11: begin p11_ff <= sub2(p11_ff, qm); state_ff <= S_UA; end
            S_UA:  begin ang_ff <= add2(ang_ff, qm); state_ff <= S_UB; end
            S_UB: begin
               bias_ff <= add2(bias_ff, qm);
               rate_ff <= sub2(gm_ff, add2(bias_ff, qm));
               state_ff <= pb_ff ? S_DEV : S_OUT;
            end
            S_DEV: begin d_ff <= sub2(zm_ff, ang_ff); state_ff <= S_X; end
            S_X:   begin d_ff <= add2(qm, gm_ff); state_ff <= S_BL; end
            S_BL:  begin ang_ff <= add2(ang_ff, qm); state_ff <= S_OUT; end
            S_OUT: begin
               rsp_ff.angle_est <= ang_ff;
               rsp_ff.rate_est  <= rate_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- tb/tb_angle_kalman_fusion.sv -----
//------------------------------------------------------------------------------
// tb_angle_kalman_fusion: self-checking bench of the angle/bias fusion filter
// A queue-fed driver offers samples under random idling and a monitor checks
// each result against an in-bench fixed-point filter, over several register
// settings, long receiver hold-offs and sender pauses.
//------------------------------------------------------------------------------
`default_nettype none
module tb_angle_kalman_fusion;
   timeunit 1ns;
   timeprecision 1ps;
   import akf_pkg::*;

   localparam int  FRAC = 16;
   localparam int  SETTLE = 200;
   localparam longint LIM_HI = 64'sd2147483647;
   localparam longint LIM_LO = -64'sd2147483648;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   angle_kalman_fusion #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_samples[$];
   rsp_type expected_estimates[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic hold_sender = 1'b0;
   logic hold_receiver = 1'b0;
   int  errors = 0;

   // filter copy: registers and state
   logic [31:0] f_angle_noise, f_rate_noise, f_meas_noise;
   logic [15:0] f_dt;
   logic signed [31:0] f_obs;
   logic        f_blend;
   longint      angle_acc, bias_acc;
   longint      cov[4];

   function automatic longint clip32(longint v);
      if (v > LIM_HI) return LIM_HI;
      if (v < LIM_LO) return LIM_LO;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint q;
      q = a * b + (64'sd1 <<< (FRAC - 1));
      return clip32(q >>> FRAC);
   endfunction

   function automatic longint fx_gain(longint pct, longint e);
      if (e <= 0) return 0;
      return clip32((pct <<< FRAC) / e);
   endfunction

   function automatic rsp_type fuse_sample(req_type s);
      longint zm, gm, dt, c, an, rn, mn;
      longint rate, d0, d1, d3, err, pct0, pct1, t1, e, k0, k1, rate_out, dev, x;
      rsp_type r;
      zm = s.angle_meas;
      gm = s.gyro_meas;
      dt = f_dt;
      c  = f_obs;
      an = f_angle_noise;
      rn = f_rate_noise;
      mn = f_meas_noise;
      rate = clip32(gm - bias_acc);
      angle_acc = clip32(angle_acc + fx_mul(rate, dt));
      d0 = clip32(an - cov[1] - cov[2]);
      d1 = clip32(-cov[3]);
      d3 = clip32(rn);
      cov[0] = clip32(cov[0] + fx_mul(d0, dt));
      cov[1] = clip32(cov[1] + fx_mul(d1, dt));
      cov[2] = clip32(cov[2] + fx_mul(d1, dt));
      cov[3] = clip32(cov[3] + fx_mul(d3, dt));
      err  = clip32(zm - angle_acc);
      pct0 = fx_mul(c, cov[0]);
      pct1 = fx_mul(c, cov[2]);
      t1   = fx_mul(c, cov[1]);
      e    = mn + fx_mul(c, pct0);
      k0 = fx_gain(pct0, e);
      k1 = fx_gain(pct1, e);
      cov[0] = clip32(cov[0] - fx_mul(k0, pct0));
      cov[1] = clip32(cov[1] - fx_mul(k0, t1));
      cov[2] = clip32(cov[2] - fx_mul(k1, pct0));
      cov[3] = clip32(cov[3] - fx_mul(k1, t1));
      angle_acc = clip32(angle_acc + fx_mul(k0, err));
      bias_acc  = clip32(bias_acc + fx_mul(k1, err));
      rate_out  = clip32(gm - bias_acc);
      if (f_blend) begin
         dev = clip32(zm - angle_acc);
         x   = clip32(fx_mul(dev, mn) + gm);
         angle_acc = clip32(angle_acc + fx_mul(x, dt));
      end
      r.angle_est = angle_acc[31:0];
      r.rate_est  = rate_out[31:0];
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097151)) - 1048576);
         2: case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return 32'($signed($urandom_range(33554431)) - 16777216);
      endcase
   endfunction

   function automatic req_type make_sample(logic [31:0] a, logic [31:0] g);
      req_type s;
      s.angle_meas = a;
      s.gyro_meas  = g;
      return s;
   endfunction

   // driver: advance on acceptance, hold the payload while stalled
   always @(posedge clock) begin
      if (!reset && (!req_valid || !req_stall)) begin
         if (req_valid)
            expected_estimates.push_back(fuse_sample(req_data));
         if (pending_samples.size() > 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_estimates.size() == 0) begin
               $display("%0t unexpected item angle_est %h rate_est %h", $time,
                        rsp_data.angle_est, rsp_data.rate_est);
               errors++;
            end else begin
               if (rsp_data.angle_est !== expected_estimates[0].angle_est) begin
                  $display("%0t angle_est expected %h actual %h", $time,
                           expected_estimates[0].angle_est, rsp_data.angle_est);
                  errors++;
               end
               if (rsp_data.rate_est !== expected_estimates[0].rate_est) begin
                  $display("%0t rate_est expected %h actual %h", $time,
                           expected_estimates[0].rate_est, rsp_data.rate_est);
                  errors++;
               end
               void'(expected_estimates.pop_front());
            end
         end
         rsp_stall <= hold_receiver || ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      case (idx)
         REG_ANGLE_NOISE: f_angle_noise = v;
         REG_RATE_NOISE:  f_rate_noise  = v;
         REG_MEAS_NOISE:  f_meas_noise  = v;
         REG_TIME_STEP:   f_dt          = v[15:0];
         REG_OBS_GAIN:    f_obs         = v;
         REG_POST_BLEND:  f_blend       = v[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || expected_estimates.size() > 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_settings(int mode);
      case (mode)
         0: begin  // defaults
            write_reg(REG_ANGLE_NOISE, 32'd66);
            write_reg(REG_RATE_NOISE, 32'd197);
            write_reg(REG_MEAS_NOISE, 32'd32768);
            write_reg(REG_TIME_STEP, 32'd655);
            write_reg(REG_OBS_GAIN, 32'd65536);
            write_reg(REG_POST_BLEND, 32'd1);
         end
         1: begin  // noises and time step at the top, gain most negative, blend off
            write_reg(REG_ANGLE_NOISE, 32'hFFFF_FFFF);
            write_reg(REG_RATE_NOISE, 32'hFFFF_FFFF);
            write_reg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
            write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
            write_reg(REG_OBS_GAIN, 32'h8000_0000);
            write_reg(REG_POST_BLEND, 32'hFFFF_FFFE);
         end
         2: begin  // zero variance: gains forced off
            write_reg(REG_ANGLE_NOISE, 32'd0);
            write_reg(REG_RATE_NOISE, 32'd0);
            write_reg(REG_MEAS_NOISE, 32'd0);
            write_reg(REG_TIME_STEP, 32'd0);
            write_reg(REG_OBS_GAIN, 32'd0);
            write_reg(REG_POST_BLEND, 32'd0);
            write_reg(3'd6, 32'hDEAD_BEEF);
            write_reg(3'd7, 32'h1234_5678);
         end
         3: begin
            write_reg(REG_OBS_GAIN, 32'h7FFF_FFFF);
            write_reg(REG_MEAS_NOISE, 32'd1);
            write_reg(REG_TIME_STEP, 32'hABCD_0100);
            write_reg(REG_POST_BLEND, 32'd1);
         end
         default: begin
            write_reg(REG_ANGLE_NOISE, $urandom_range(1) ? $urandom : $urandom_range(4095));
            write_reg(REG_RATE_NOISE, $urandom_range(1) ? $urandom : $urandom_range(4095));
            write_reg(REG_MEAS_NOISE, $urandom_range(1) ? $urandom : $urandom_range(131071));
            write_reg(REG_TIME_STEP, $urandom);
            write_reg(REG_OBS_GAIN, $urandom_range(1) ? $urandom
                                    : 32'($signed($urandom_range(262143)) - 131072));
            write_reg(REG_POST_BLEND, $urandom);
         end
      endcase
   endtask

   initial begin
      f_angle_noise = 32'd66;
      f_rate_noise  = 32'd197;
      f_meas_noise  = 32'd32768;
      f_dt          = 16'd655;
      f_obs         = 32'sd65536;
      f_blend       = 1'b1;
      angle_acc = 0;
      bias_acc  = 0;
      cov[0] = 64'sd1 <<< FRAC;
      cov[1] = 0;
      cov[2] = 0;
      cov[3] = 64'sd1 <<< FRAC;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes under the reset settings
      pending_samples.push_back(make_sample(32'h0, 32'h0));
      pending_samples.push_back(make_sample(32'h0001_0000, 32'h0));
      pending_samples.push_back(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_samples.push_back(make_sample(32'h8000_0000, 32'h8000_0000));
      pending_samples.push_back(make_sample(32'h7FFF_FFFF, 32'h8000_0000));
      pending_samples.push_back(make_sample(32'h8000_0000, 32'h7FFF_FFFF));
      pending_samples.push_back(make_sample(32'hFFFF_FFFF, 32'h0000_0001));
      pending_samples.push_back(make_sample(32'h0000_0001, 32'hFFFF_FFFF));
      pending_samples.push_back(make_sample(32'h5555_5555, 32'hAAAA_AAAA));
      pending_samples.push_back(make_sample(32'hAAAA_AAAA, 32'h5555_5555));
      drain();
      // overflow settings, the zero-variance case, then the largest gain
      for (int m = 1; m <= 3; m++) begin
         load_settings(m);
         repeat (4) pending_samples.push_back(make_sample(pick_word(), pick_word()));
         pending_samples.push_back(make_sample(32'h7FFF_FFFF, 32'h8000_0000));
         drain();
      end

      // random phases over the idling modes
      for (int ph = 0; ph < 8; ph++) begin
         load_settings(ph < 4 ? ph : 4 + ph);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         for (int i = 0; i < 75; i++)
            pending_samples.push_back(make_sample(pick_word(), pick_word()));
         if (ph == 1) begin
            // let an item get in flight, then hold the sender off until
            // every result is back
            while (expected_estimates.size() == 0) @(posedge clock);
            hold_sender <= 1'b1;
            @(posedge clock);
            while (expected_estimates.size() > 0 || req_valid) @(posedge clock);
            hold_sender <= 1'b0;
         end
         if (ph == 0 || ph == 5) begin
            // back-pressure: receiver holds off while samples keep coming
            hold_receiver <= 1'b1;
            repeat (800) @(posedge clock);
            hold_receiver <= 1'b0;
         end
         for (int i = 0; i < 75; i++)
            pending_samples.push_back(make_sample(pick_word(), pick_word()));
         drain();
      end

      if (errors == 0)
         $display("** angle_kalman_fusion: PASSED **");
      else
         $display("** angle_kalman_fusion: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** angle_kalman_fusion: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
